// ===== rtl/fwrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the warm-up / release controller.
// No dependencies; used by the interfaces, the step logic and the top level.
package fwrc_pkg;

   localparam int BOUND_W     = 24;
   localparam int TICK_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // phase codes
   localparam logic [1:0] PH_COLD    = 2'd0;
   localparam logic [1:0] PH_BUILDUP = 2'd1;
   localparam logic [1:0] PH_RELEASE = 2'd2;

   // event codes
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;
   localparam logic [1:0] FUNC_REQ   = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TICK_PERIOD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BUILDUP_TIME = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REBUILD_TIME = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_TIME = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_TIME   = 3'd4;

   // register reset values
   localparam logic [TICK_W-1:0]  RST_TICK_PERIOD  = 16'd10;
   localparam logic [BOUND_W-1:0] RST_BUILDUP_TIME = 24'd60000;
   localparam logic [BOUND_W-1:0] RST_REBUILD_TIME = 24'd10000;
   localparam logic [BOUND_W-1:0] RST_RELEASE_TIME = 24'd5000;
   localparam logic [BOUND_W-1:0] RST_PRESS_TIME   = 24'd500;

   typedef struct packed {
      logic [TICK_W-1:0]  tick_period;
      logic [BOUND_W-1:0] buildup_time;
      logic [BOUND_W-1:0] rebuild_time;
      logic [BOUND_W-1:0] release_time;
      logic [BOUND_W-1:0] press_time;
   } cfg_type;

   // controller state other than the timer
   typedef struct packed {
      logic [1:0]         phase;
      logic [BOUND_W-1:0] bound;
      logic               enabled;
      logic               pending;
      logic               ready_flag;
      logic               warmup_level;
      logic               release_level;
   } ctl_type;

endpackage

// ===== rtl/fwrc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: event requests, responses, register writes.
// Depends on fwrc_pkg for field widths.
interface fwrc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       release_value;
   modport source (output valid, output func, output release_value, input ready);
   modport sink (input valid, input func, input release_value, output ready);
endinterface

interface fwrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] phase;
   logic       warmup_pin_level;
   logic       release_pin_level;
   logic       ready_to_release;
   modport source (output valid, output phase, output warmup_pin_level,
                   output release_pin_level, output ready_to_release, input ready);
   modport sink (input valid, input phase, input warmup_pin_level,
                 input release_pin_level, input ready_to_release, output ready);
endinterface

interface fwrc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [fwrc_pkg::CSR_INDEX_W-1:0]   index;
   logic [fwrc_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fog_warmup_release_controller_top.sv =====
`timescale 1ns / 1ps
// Top level of the warm-up / release controller.
// Depends on fwrc_pkg, fwrc_if and fwrc_event_step.
//
// Usage:
//   req  : event transactions (func: tick, start, stop-then-tick, release
//          request; release_value for requests). One response per event.
//   rsp  : phase, heater pin level, release pin level (both active low) and
//          the ready flag as they stand after the event.
//   csr  : register writes (index, data), always ready. Write only while the
//          controller is idle; indexes past the press time are dropped.
// Response: valid in the cycle after its event is accepted.
// Throughput: one event per cycle unless the response stalls; the full state update is a single
//   saturating add plus a handful of compares ahead of the state register.
// Reset: phase cold, timer zero, heater and release pins off (high),
//   registers at their defaults, no response pending.
// Stall: the response register holds while rsp.ready is low; req.ready then
//   drops, and rises again in the same cycle the response is taken.
module fog_warmup_release_controller_top #(
   parameter int TIMER_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   fwrc_req_if.sink   req,
   fwrc_rsp_if.source rsp,
   fwrc_csr_if.sink   csr
);

   fwrc_pkg::cfg_type      cfg_ff, cfg_in;
   fwrc_pkg::ctl_type      ctl_ff, ctl_in;
   fwrc_pkg::ctl_type      ctl_step;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [TIMER_WIDTH-1:0] elapsed_step;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   req_take;

   // Accept when the response slot is empty or being drained this cycle.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   fwrc_event_step #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_step (
      .func         (req.func),
      .release_value(req.release_value),
      .cfg          (cfg_ff),
      .ctl_cur      (ctl_ff),
      .elapsed_cur  (elapsed_ff),
      .ctl_nxt      (ctl_step),
      .elapsed_nxt  (elapsed_step)
   );

   // Advance state only on an accepted transaction.
   assign ctl_in     = req_take ? ctl_step : ctl_ff;
   assign elapsed_in = req_take ? elapsed_step : elapsed_ff;

   // Hold the response until taken; a new transaction refills the slot.
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp.ready);

   // Register writes: truncate data to the register width, drop unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid && csr.ready) begin
         case (csr.index)
            fwrc_pkg::REG_TICK_PERIOD:  cfg_in.tick_period  = csr.data[fwrc_pkg::TICK_W-1:0];
            fwrc_pkg::REG_BUILDUP_TIME: cfg_in.buildup_time = csr.data;
            fwrc_pkg::REG_REBUILD_TIME: cfg_in.rebuild_time = csr.data;
            fwrc_pkg::REG_RELEASE_TIME: cfg_in.release_time = csr.data;
            fwrc_pkg::REG_PRESS_TIME:   cfg_in.press_time   = csr.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period  <= fwrc_pkg::RST_TICK_PERIOD;
         cfg_ff.buildup_time <= fwrc_pkg::RST_BUILDUP_TIME;
         cfg_ff.rebuild_time <= fwrc_pkg::RST_REBUILD_TIME;
         cfg_ff.release_time <= fwrc_pkg::RST_RELEASE_TIME;
         cfg_ff.press_time   <= fwrc_pkg::RST_PRESS_TIME;
         ctl_ff.phase         <= fwrc_pkg::PH_COLD;
         ctl_ff.bound         <= fwrc_pkg::RST_BUILDUP_TIME;
         ctl_ff.enabled       <= 1'b0;
         ctl_ff.pending       <= 1'b0;
         ctl_ff.ready_flag    <= 1'b0;
         ctl_ff.warmup_level  <= 1'b1;
         ctl_ff.release_level <= 1'b1;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         ctl_ff       <= ctl_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The state register doubles as the response register: it changes only
   // when a new transaction is accepted, which frees the slot first.
   assign rsp.valid             = rsp_valid_ff;
   assign rsp.phase             = ctl_ff.phase;
   assign rsp.warmup_pin_level  = ctl_ff.warmup_level;
   assign rsp.release_pin_level = ctl_ff.release_level;
   assign rsp.ready_to_release  = ctl_ff.ready_flag;

endmodule

// ===== rtl/fwrc_event_step.sv =====
`timescale 1ns / 1ps
// Next-state logic for one event: timer advance, phase transitions, actions.
// Depends on fwrc_pkg.
module fwrc_event_step #(
   parameter int TIMER_WIDTH = 24
) (
   input  logic [1:0]             func,
   input  logic                   release_value,
   input  fwrc_pkg::cfg_type      cfg,
   input  fwrc_pkg::ctl_type      ctl_cur,
   input  logic [TIMER_WIDTH-1:0] elapsed_cur,
   output fwrc_pkg::ctl_type      ctl_nxt,
   output logic [TIMER_WIDTH-1:0] elapsed_nxt
);

   localparam int CMP_W = (TIMER_WIDTH > fwrc_pkg::BOUND_W) ? TIMER_WIDTH : fwrc_pkg::BOUND_W;

   logic [TIMER_WIDTH:0]   sum;
   logic [TIMER_WIDTH-1:0] sat;

   assign sum = {1'b0, elapsed_cur} + (TIMER_WIDTH+1)'(cfg.tick_period);
   assign sat = sum[TIMER_WIDTH] ? {TIMER_WIDTH{1'b1}} : sum[TIMER_WIDTH-1:0];

   always_comb begin
      logic                   tick;
      logic [TIMER_WIDTH-1:0] el;
      fwrc_pkg::ctl_type      st;

      st   = ctl_cur;
      el   = elapsed_cur;
      tick = 1'b0;

      case (func)
         fwrc_pkg::FUNC_TICK: begin
            tick = 1'b1;
         end
         fwrc_pkg::FUNC_START: begin
            st.enabled = 1'b1;
         end
         fwrc_pkg::FUNC_STOP: begin
            st.enabled = 1'b0;
            tick       = 1'b1;
         end
         fwrc_pkg::FUNC_REQ: begin
            if (release_value && st.ready_flag) begin
               st.pending = 1'b1;
            end
            if (!release_value) begin
               st.pending = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (tick) begin
         el = sat;
         case (ctl_cur.phase)
            fwrc_pkg::PH_COLD: begin
               if (st.enabled) begin
                  st.phase        = fwrc_pkg::PH_BUILDUP;
                  el              = '0;
                  st.ready_flag   = 1'b0;
                  st.warmup_level = 1'b0;
                  st.bound        = cfg.buildup_time;
               end
            end
            fwrc_pkg::PH_BUILDUP: begin
               if (!st.enabled) begin
                  st.phase        = fwrc_pkg::PH_COLD;
                  st.warmup_level = 1'b1;
               end else if (st.pending) begin
                  st.phase         = fwrc_pkg::PH_RELEASE;
                  st.pending       = 1'b0;
                  st.ready_flag    = 1'b0;
                  el               = '0;
                  st.release_level = 1'b0;
               end
               if (CMP_W'(el) >= CMP_W'(st.bound)) begin
                  st.ready_flag = 1'b1;
               end
               if (CMP_W'(el) >= CMP_W'(cfg.press_time) && CMP_W'(el) < CMP_W'(st.bound)) begin
                  st.release_level = 1'b1;
               end
            end
            fwrc_pkg::PH_RELEASE: begin
               if (!st.enabled) begin
                  st.phase         = fwrc_pkg::PH_COLD;
                  st.ready_flag    = 1'b0;
                  el               = '0;
                  st.warmup_level  = 1'b1;
                  st.release_level = 1'b1;
               end else if (CMP_W'(el) >= CMP_W'(cfg.release_time)) begin
                  st.phase         = fwrc_pkg::PH_BUILDUP;
                  el               = '0;
                  st.ready_flag    = 1'b0;
                  st.release_level = 1'b0;
                  st.bound         = cfg.rebuild_time;
               end
               if (CMP_W'(el) >= CMP_W'(cfg.press_time)
                   && CMP_W'(el) < CMP_W'(cfg.release_time)) begin
                  st.release_level = 1'b1;
               end
            end
            default: begin
               // unused phase code: only the timer moves
            end
         endcase
      end

      ctl_nxt     = st;
      elapsed_nxt = el;
   end

endmodule

// ===== rtl/fwrc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the warm-up / release controller, bound to the top.
// Depends on fwrc_pkg and fog_warmup_release_controller_top.
module fwrc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_phase,
   input logic       rsp_warmup_pin_level,
   input logic       rsp_release_pin_level,
   input logic       rsp_ready_to_release
);

   // every accepted event yields a response on the next cycle
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after accepted event");

   // a draining response never blocks the request side
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response drains");

   // heater is off exactly in the cold phase
   a_heater_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_phase == fwrc_pkg::PH_COLD) == rsp_warmup_pin_level))
      else $error("heater level disagrees with phase");

   // the unused phase code never appears
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase != 2'd3))
      else $error("unused phase code on response");

   // a stalled response holds its phase, release pin level and ready flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_release_pin_level) && $stable(rsp_ready_to_release))
      else $error("stalled response changed");

endmodule

bind fog_warmup_release_controller_top fwrc_checker u_fwrc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req.valid),
   .req_ready            (req.ready),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_phase            (rsp.phase),
   .rsp_warmup_pin_level (rsp.warmup_pin_level),
   .rsp_release_pin_level(rsp.release_pin_level),
   .rsp_ready_to_release (rsp.ready_to_release)
);

// ===== dv/tb_fog_warmup_release_controller_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the warm-up / release controller top level.
// Depends on fwrc_pkg, the fwrc_if channel interfaces and the RTL top module.
module tb_fog_warmup_release_controller_top;

   localparam int TIMER_W = 24;
   // first register index past the implemented ones; writes there are dropped
   localparam logic [fwrc_pkg::CSR_INDEX_W-1:0] REG_FIRST_UNUSED =
      fwrc_pkg::REG_PRESS_TIME + 3'd1;

   typedef struct packed {
      logic [1:0] func;
      logic       release_value;
   } ctl_event_type;

   typedef struct packed {
      logic [1:0] phase;
      logic       warmup_level;
      logic       release_level;
      logic       ready_flag;
   } pin_status_type;

   logic clock;
   logic reset;

   fwrc_req_if req ();
   fwrc_rsp_if rsp ();
   fwrc_csr_if csr ();

   fog_warmup_release_controller_top #(
      .TIMER_WIDTH(TIMER_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp),
      .csr  (csr)
   );

   // events waiting to be offered, and pin status forecast per accepted event
   ctl_event_type  pending_events[$];
   pin_status_type status_forecast[$];
   ctl_event_type  next_event;
   pin_status_type oldest_status;

   // shadow of the controller: register copy, control state and timer
   fwrc_pkg::cfg_type    reg_cfg;
   fwrc_pkg::ctl_type    controller;
   logic [TIMER_W-1:0]   timer_ms;

   int idle_pct;
   int mismatch_count;

   // Clock: 12 ns period.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net: end the run if the controller stops making progress.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Advance the shadow controller by one event and return the pin status it ends in.
   // A stop clears the enable first and then runs a full tick.
   function automatic pin_status_type step_controller(input logic [1:0] func,
                                                      input logic rel_value);
      logic [TIMER_W:0] sum;
      pin_status_type   status;
      if (func == fwrc_pkg::FUNC_START)
         controller.enabled = 1'b1;
      if (func == fwrc_pkg::FUNC_STOP)
         controller.enabled = 1'b0;
      if (func == fwrc_pkg::FUNC_REQ) begin
         // a request only latches while ready; a withdrawal always clears
         if (rel_value && controller.ready_flag)
            controller.pending = 1'b1;
         if (!rel_value)
            controller.pending = 1'b0;
      end
      if (func == fwrc_pkg::FUNC_TICK || func == fwrc_pkg::FUNC_STOP) begin
         // saturating timer add, then the transition and the actions of the
         // phase that was current when the tick began
         sum = {1'b0, timer_ms} + (TIMER_W+1)'(reg_cfg.tick_period);
         timer_ms = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
         case (controller.phase)
            fwrc_pkg::PH_COLD: begin
               if (controller.enabled) begin
                  controller.phase        = fwrc_pkg::PH_BUILDUP;
                  timer_ms                = '0;
                  controller.ready_flag   = 1'b0;
                  controller.warmup_level = 1'b0;
                  controller.bound        = reg_cfg.buildup_time;
               end
            end
            fwrc_pkg::PH_BUILDUP: begin
               if (!controller.enabled) begin
                  controller.phase        = fwrc_pkg::PH_COLD;
                  controller.warmup_level = 1'b1;
               end else if (controller.pending) begin
                  controller.phase         = fwrc_pkg::PH_RELEASE;
                  controller.pending       = 1'b0;
                  controller.ready_flag    = 1'b0;
                  timer_ms                 = '0;
                  controller.release_level = 1'b0;
               end
               if (timer_ms >= controller.bound)
                  controller.ready_flag = 1'b1;
               if (timer_ms >= reg_cfg.press_time && timer_ms < controller.bound)
                  controller.release_level = 1'b1;
            end
            fwrc_pkg::PH_RELEASE: begin
               if (!controller.enabled) begin
                  controller.phase         = fwrc_pkg::PH_COLD;
                  controller.ready_flag    = 1'b0;
                  timer_ms                 = '0;
                  controller.warmup_level  = 1'b1;
                  controller.release_level = 1'b1;
               end else if (timer_ms >= reg_cfg.release_time) begin
                  controller.phase         = fwrc_pkg::PH_BUILDUP;
                  timer_ms                 = '0;
                  controller.ready_flag    = 1'b0;
                  controller.release_level = 1'b0;
                  controller.bound         = reg_cfg.rebuild_time;
               end
               if (timer_ms >= reg_cfg.press_time && timer_ms < reg_cfg.release_time)
                  controller.release_level = 1'b1;
            end
            default: ;
         endcase
      end
      status.phase         = controller.phase;
      status.warmup_level  = controller.warmup_level;
      status.release_level = controller.release_level;
      status.ready_flag    = controller.ready_flag;
      return status;
   endfunction

   task automatic flag_mismatch(input string field, input logic [1:0] want,
                                input logic [1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s at %0t: expected %0d, got %0d", field, $time, want, got);
   endtask

   // Event driver: offer the next queued event, holding it until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_event        = pending_events.pop_front();
            req.valid         <= 1'b1;
            req.func          <= next_event.func;
            req.release_value <= next_event.release_value;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Response sink: stall at random.
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= idle_pct);
   end

   // Monitor: forecast each accepted event, then check each accepted response
   // against the oldest forecast. Forecast first so ordering never matters.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            status_forecast.push_back(step_controller(req.func, req.release_value));
         if (rsp.valid && rsp.ready) begin
            if (status_forecast.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response at %0t with no transaction outstanding", $time);
            end else begin
               oldest_status = status_forecast.pop_front();
               if (rsp.phase !== oldest_status.phase)
                  flag_mismatch("phase", oldest_status.phase, rsp.phase);
               if (rsp.warmup_pin_level !== oldest_status.warmup_level)
                  flag_mismatch("warmup_pin_level", {1'b0, oldest_status.warmup_level},
                                {1'b0, rsp.warmup_pin_level});
               if (rsp.release_pin_level !== oldest_status.release_level)
                  flag_mismatch("release_pin_level", {1'b0, oldest_status.release_level},
                                {1'b0, rsp.release_pin_level});
               if (rsp.ready_to_release !== oldest_status.ready_flag)
                  flag_mismatch("ready_to_release", {1'b0, oldest_status.ready_flag},
                                {1'b0, rsp.ready_to_release});
            end
         end
      end
   end

   // Write one register and mirror it into the shadow copy once accepted.
   task automatic write_reg(input logic [fwrc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [fwrc_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (index)
         fwrc_pkg::REG_TICK_PERIOD:  reg_cfg.tick_period  = value[fwrc_pkg::TICK_W-1:0];
         fwrc_pkg::REG_BUILDUP_TIME: reg_cfg.buildup_time = value;
         fwrc_pkg::REG_REBUILD_TIME: reg_cfg.rebuild_time = value;
         fwrc_pkg::REG_RELEASE_TIME: reg_cfg.release_time = value;
         fwrc_pkg::REG_PRESS_TIME:   reg_cfg.press_time   = value;
         default: ;
      endcase
   endtask

   // Wait until every queued event is sent and every forecast is answered,
   // then give the registered response a little slack.
   task automatic settle();
      do @(negedge clock);
      while (pending_events.size() != 0 || status_forecast.size() != 0 || req.valid);
      repeat (2) @(negedge clock);
   endtask

   task automatic push_event(input logic [1:0] func, input logic rel_value);
      pending_events.push_back('{func: func, release_value: rel_value});
   endtask

   // Random events with a weighted mix; requests mostly ask to release so
   // that sequences reach the release phase. Stops take what is left.
   task automatic queue_random_events(input int count, input int tick_pct,
                                      input int req_pct, input int start_pct);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < tick_pct)
            push_event(fwrc_pkg::FUNC_TICK, 1'($urandom_range(1)));
         else if (r < tick_pct + req_pct)
            push_event(fwrc_pkg::FUNC_REQ, $urandom_range(99) < 80);
         else if (r < tick_pct + req_pct + start_pct)
            push_event(fwrc_pkg::FUNC_START, 1'($urandom_range(1)));
         else
            push_event(fwrc_pkg::FUNC_STOP, 1'($urandom_range(1)));
      end
   endtask

   // Drain, program a full register set (plus one dropped write), then queue events.
   task automatic run_setting(input logic [fwrc_pkg::TICK_W-1:0] tick,
                              input logic [fwrc_pkg::BOUND_W-1:0] buildup,
                              input logic [fwrc_pkg::BOUND_W-1:0] rebuild,
                              input logic [fwrc_pkg::BOUND_W-1:0] rel_time,
                              input logic [fwrc_pkg::BOUND_W-1:0] press, input int count,
                              input int tick_pct, input int req_pct, input int start_pct,
                              input int idle);
      settle();
      write_reg(fwrc_pkg::REG_TICK_PERIOD,
                {{(fwrc_pkg::CSR_DATA_W - fwrc_pkg::TICK_W){1'b0}}, tick});
      write_reg(fwrc_pkg::REG_BUILDUP_TIME, buildup);
      write_reg(fwrc_pkg::REG_REBUILD_TIME, rebuild);
      write_reg(fwrc_pkg::REG_RELEASE_TIME, rel_time);
      write_reg(fwrc_pkg::REG_PRESS_TIME, press);
      write_reg(fwrc_pkg::CSR_INDEX_W'(REG_FIRST_UNUSED + $urandom_range(2)),
                fwrc_pkg::CSR_DATA_W'($urandom_range(24'hFFFFFF)));
      @(negedge clock);
      idle_pct = idle;
      queue_random_events(count, tick_pct, req_pct, start_pct);
   endtask

   // Stimulus sequencer.
   initial begin
      logic [fwrc_pkg::TICK_W-1:0] tick;
      int unsigned                 unit;

      // drive every input to a known value from time zero
      reset             = 1'b1;
      req.valid         = 1'b0;
      req.func          = fwrc_pkg::FUNC_TICK;
      req.release_value = 1'b0;
      rsp.ready         = 1'b0;
      csr.valid         = 1'b0;
      csr.index         = fwrc_pkg::REG_TICK_PERIOD;
      csr.data          = '0;
      idle_pct          = 19;
      mismatch_count    = 0;

      reg_cfg = '{tick_period: fwrc_pkg::RST_TICK_PERIOD,
                  buildup_time: fwrc_pkg::RST_BUILDUP_TIME,
                  rebuild_time: fwrc_pkg::RST_REBUILD_TIME,
                  release_time: fwrc_pkg::RST_RELEASE_TIME,
                  press_time: fwrc_pkg::RST_PRESS_TIME};
      controller = '{phase: fwrc_pkg::PH_COLD, bound: fwrc_pkg::RST_BUILDUP_TIME,
                     enabled: 1'b0, pending: 1'b0, ready_flag: 1'b0,
                     warmup_level: 1'b1, release_level: 1'b1};
      timer_ms = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: ticks in cold, a request while not ready, start, stop
      // from buildup.
      push_event(fwrc_pkg::FUNC_TICK, 1'b0);
      push_event(fwrc_pkg::FUNC_REQ, 1'b1);
      push_event(fwrc_pkg::FUNC_START, 1'b0);
      push_event(fwrc_pkg::FUNC_TICK, 1'b1);
      push_event(fwrc_pkg::FUNC_STOP, 1'b0);
      settle();

      // Short timings for a walk through every phase: ready, request and
      // withdrawal, release, press window, return on the rebuild bound, stop
      // out of release.
      write_reg(fwrc_pkg::REG_TICK_PERIOD, 24'd100);
      write_reg(fwrc_pkg::REG_BUILDUP_TIME, 24'd300);
      write_reg(fwrc_pkg::REG_REBUILD_TIME, 24'd200);
      write_reg(fwrc_pkg::REG_RELEASE_TIME, 24'd300);
      write_reg(fwrc_pkg::REG_PRESS_TIME, 24'd150);
      write_reg(REG_FIRST_UNUSED, 24'd7);
      @(negedge clock);
      push_event(fwrc_pkg::FUNC_REQ, 1'b1);
      push_event(fwrc_pkg::FUNC_REQ, 1'b0);
      push_event(fwrc_pkg::FUNC_START, 1'b1);
      repeat (4) push_event(fwrc_pkg::FUNC_TICK, 1'b0);
      push_event(fwrc_pkg::FUNC_REQ, 1'b1);
      push_event(fwrc_pkg::FUNC_REQ, 1'b0);
      push_event(fwrc_pkg::FUNC_REQ, 1'b1);
      repeat (6) push_event(fwrc_pkg::FUNC_TICK, 1'b1);
      push_event(fwrc_pkg::FUNC_REQ, 1'b1);
      push_event(fwrc_pkg::FUNC_TICK, 1'b0);
      push_event(fwrc_pkg::FUNC_STOP, 1'b1);

      // Random phases: short timings, all-zero bounds with the smallest tick,
      // then the largest values with a tick-heavy mix and no idling so the
      // timer saturates.
      run_setting(16'd50, 24'd400, 24'd200, 24'd300, 24'd100, 100, 60, 25, 10, 19);
      run_setting(16'd1, 24'd0, 24'd0, 24'd0, 24'd0, 50, 55, 30, 10, 19);
      run_setting(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 270,
                  97, 1, 1, 0);

      // Random timings scaled to the tick so every phase is reachable.
      repeat (3) begin
         tick = fwrc_pkg::TICK_W'($urandom_range(65535, 1));
         unit = 32'(tick);
         run_setting(tick,
                     fwrc_pkg::BOUND_W'(unit * $urandom_range(6) + $urandom_range(unit)),
                     fwrc_pkg::BOUND_W'(unit * $urandom_range(6) + $urandom_range(unit)),
                     fwrc_pkg::BOUND_W'(unit * $urandom_range(6) + $urandom_range(unit)),
                     fwrc_pkg::BOUND_W'(unit * $urandom_range(6) + $urandom_range(unit)),
                     40, 55, 30, 10, 19);
      end

      settle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && status_forecast.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
